>>> design/pdcm_pkg.sv
`default_nettype none
package pdcm_pkg;

    localparam int CNT_W   = 16;
    localparam int TO_W    = 16;
    localparam int DUTY_W  = 7;
    localparam int STAT_W  = 2;
    localparam int PROD_W  = CNT_W + DUTY_W;
    localparam int QBITS   = DUTY_W;
    localparam int STEP_W  = $clog2(QBITS);

    localparam logic [TO_W-1:0]   TIMEOUT_RESET = TO_W'(50000);
    localparam logic [DUTY_W-1:0] PERCENT_SCALE = DUTY_W'(100);
    localparam logic [DUTY_W-1:0] DUTY_ZERO     = '0;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO    = 2'd2;

    typedef enum logic [1:0] {
        RES_TIMEOUT = 2'd0,
        RES_ZERO    = 2'd1,
        RES_SAT     = 2'd2,
        RES_QUO     = 2'd3
    } t_res;

    typedef struct packed {
        logic tick;
        logic cap_rise;
        logic cap_fall;
        logic clr_wait;
        logic inc_wait;
        logic calc;
        logic mul;
        logic div_step;
        logic load_out;
        t_res res;
    } t_dp_cmd;

    typedef struct packed {
        logic rising;
        logic falling;
        logic wait_hit;
        logic zero_period;
        logic saturate;
        logic div_last;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> design/pdcm_ctrl.sv
`default_nettype none
module pdcm_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_action,
    output logic              o_valid,
    input  wire               i_stall,
    input  wire pdcm_pkg::t_dp_sts i_sts,
    output pdcm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_RUN  = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_RISE1 = 4'b0010,
        PH_FALL  = 4'b0100,
        PH_RISE2 = 4'b1000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_out_valid;
    logic   acc;
    logic   out_free;
    logic   hit;

    assign o_stall  = (r_state != S_RUN) || (r_out_valid && i_stall);
    assign out_free = !r_out_valid || !i_stall;
    assign acc      = i_valid && !o_stall;
    assign hit      = (r_phase == PH_FALL) ? i_sts.falling : i_sts.rising;
    assign o_valid  = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            S_RUN: begin
                if (acc) begin
                    if (i_action) begin
                        // restart: drop any measurement in progress
                        n_phase        = PH_RISE1;
                        o_cmd.clr_wait = 1'b1;
                    end else begin
                        o_cmd.tick = 1'b1;
                        if (r_phase != PH_IDLE) begin
                            if (hit) begin
                                o_cmd.clr_wait = 1'b1;
                                unique case (r_phase)
                                    PH_RISE1: begin
                                        o_cmd.cap_rise = 1'b1;
                                        n_phase        = PH_FALL;
                                    end
                                    PH_FALL: begin
                                        o_cmd.cap_fall = 1'b1;
                                        n_phase        = PH_RISE2;
                                    end
                                    PH_RISE2: begin
                                        o_cmd.calc = 1'b1;
                                        n_phase    = PH_IDLE;
                                        n_state    = S_MUL;
                                    end
                                    default: n_phase = PH_IDLE;
                                endcase
                            end else if (i_sts.wait_hit) begin
                                o_cmd.clr_wait = 1'b1;
                                o_cmd.load_out = 1'b1;
                                o_cmd.res      = pdcm_pkg::RES_TIMEOUT;
                                n_phase        = PH_IDLE;
                            end else begin
                                o_cmd.inc_wait = 1'b1;
                            end
                        end
                    end
                end
            end
            S_MUL: begin
                if (i_sts.zero_period) begin
                    if (out_free) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.res      = pdcm_pkg::RES_ZERO;
                        n_state        = S_RUN;
                    end
                end else if (i_sts.saturate) begin
                    if (out_free) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.res      = pdcm_pkg::RES_SAT;
                        n_state        = S_RUN;
                    end
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.res      = pdcm_pkg::RES_QUO;
                    n_state        = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/pdcm_dp.sv
`default_nettype none
module pdcm_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_level,
    input  wire                              i_cfg_wr_en,
    input  wire  [pdcm_pkg::TO_W-1:0]        i_cfg_wr_data,
    input  wire  pdcm_pkg::t_dp_cmd          i_cmd,
    output pdcm_pkg::t_dp_sts                o_sts,
    output logic [pdcm_pkg::DUTY_W-1:0]      o_duty_percent,
    output logic [pdcm_pkg::STAT_W-1:0]      o_status
);

    logic [pdcm_pkg::CNT_W-1:0]  r_tick;
    logic [pdcm_pkg::CNT_W-1:0]  r_rise;
    logic [pdcm_pkg::CNT_W-1:0]  r_fall;
    logic [pdcm_pkg::TO_W-1:0]   r_wait;
    logic                        r_last_level;
    logic [pdcm_pkg::TO_W-1:0]   r_timeout;
    logic [pdcm_pkg::CNT_W-1:0]  r_period;
    logic [pdcm_pkg::CNT_W-1:0]  r_high;
    logic [pdcm_pkg::PROD_W-1:0] r_rem;
    logic [pdcm_pkg::QBITS-1:0]  r_quo;
    logic [pdcm_pkg::STEP_W-1:0] r_step;
    logic [pdcm_pkg::DUTY_W-1:0] r_duty;
    logic [pdcm_pkg::STAT_W-1:0] r_status;

    logic [pdcm_pkg::CNT_W-1:0]  tick_next;
    logic [pdcm_pkg::TO_W-1:0]   wait_next;
    logic [pdcm_pkg::TO_W-1:0]   limit;
    logic [pdcm_pkg::PROD_W-1:0] div_sh;
    logic                        div_ge;

    assign tick_next = r_tick + 1'b1;
    assign wait_next = r_wait + 1'b1;
    // a zero limit acts like one
    assign limit     = (r_timeout == '0) ? pdcm_pkg::TO_W'(1) : r_timeout;
    assign div_sh    = pdcm_pkg::PROD_W'(r_period) << r_step;
    assign div_ge    = r_rem >= div_sh;

    assign o_sts.rising      = i_level && !r_last_level;
    assign o_sts.falling     = !i_level && r_last_level;
    assign o_sts.wait_hit    = wait_next >= limit;
    assign o_sts.zero_period = (r_period == '0);
    assign o_sts.saturate    = (r_high > r_period);
    assign o_sts.div_last    = (r_step == '0);

    assign o_duty_percent = r_duty;
    assign o_status       = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_rise       <= '0;
            r_fall       <= '0;
            r_wait       <= '0;
            r_last_level <= 1'b0;
            r_timeout    <= pdcm_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_cmd.tick) begin
                r_tick       <= tick_next;
                r_last_level <= i_level;
            end
            // an edge captures the count after this tick's advance
            if (i_cmd.cap_rise) begin
                r_rise <= tick_next;
            end
            if (i_cmd.cap_fall) begin
                r_fall <= tick_next;
            end
            if (i_cmd.clr_wait) begin
                r_wait <= '0;
            end else if (i_cmd.inc_wait) begin
                r_wait <= wait_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_period <= tick_next - r_rise;
            r_high   <= r_fall - r_rise;
        end
        if (i_cmd.mul) begin
            r_rem  <= pdcm_pkg::PROD_W'(r_high) * pdcm_pkg::PROD_W'(pdcm_pkg::PERCENT_SCALE);
            r_quo  <= '0;
            r_step <= pdcm_pkg::STEP_W'(pdcm_pkg::QBITS - 1);
        end else if (i_cmd.div_step) begin
            // restoring division, one quotient bit per cycle, MSB first
            if (div_ge) begin
                r_rem         <= r_rem - div_sh;
                r_quo[r_step] <= 1'b1;
            end
            r_step <= r_step - 1'b1;
        end
        if (i_cmd.load_out) begin
            unique case (i_cmd.res)
                pdcm_pkg::RES_TIMEOUT: begin
                    r_duty   <= pdcm_pkg::DUTY_ZERO;
                    r_status <= pdcm_pkg::ST_TIMEOUT;
                end
                pdcm_pkg::RES_ZERO: begin
                    r_duty   <= pdcm_pkg::DUTY_ZERO;
                    r_status <= pdcm_pkg::ST_ZERO;
                end
                pdcm_pkg::RES_SAT: begin
                    r_duty   <= pdcm_pkg::PERCENT_SCALE;
                    r_status <= pdcm_pkg::ST_OK;
                end
                pdcm_pkg::RES_QUO: begin
                    r_duty   <= r_quo;
                    r_status <= pdcm_pkg::ST_OK;
                end
                default: begin
                    r_duty   <= pdcm_pkg::DUTY_ZERO;
                    r_status <= pdcm_pkg::ST_OK;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/pwm_duty_cycle_meter_core.sv
// PWM duty-cycle meter, one measurement per start item.
// Input channel (i_valid / o_stall): each item is either a start (i_action = 1),
// which arms the meter, or a tick (i_action = 0) carrying the sampled pin level
// in i_level. Ticks advance a 16-bit free-running counter; the meter captures it
// at a rising edge, the following falling edge and the next rising edge.
// Output channel (o_valid / i_stall): one item per finished measurement with
// o_duty_percent and o_status (ok, timeout, zero period).
// Throughput: one input item per cycle while no result waits on a stalled output,
// except the tick that closes a measurement: the input then stalls through the
// multiply stage and, unless the period is zero or over-range, through the 7-step
// restoring divider that produces the percentage one bit per cycle.
// A timeout result is loaded into the output register by its accepting edge;
// other results are loaded from the multiply state or from the done state.
// A result waits in the output register while i_stall is high, and the input
// stalls for as long as a result waits there. i_cfg_wr_en writes the timeout
// limit from i_cfg_wr_data.
// Synchronous reset (i_rst_n low) clears the counters and captures, goes idle,
// drops any pending result and restores the timeout limit to 50000.
`default_nettype none
module pwm_duty_cycle_meter_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_action,
    input  wire                              i_level,
    input  wire                              i_cfg_wr_en,
    input  wire  [pdcm_pkg::TO_W-1:0]        i_cfg_wr_data,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [pdcm_pkg::DUTY_W-1:0]      o_duty_percent,
    output logic [pdcm_pkg::STAT_W-1:0]      o_status
);

    pdcm_pkg::t_dp_cmd cmd;
    pdcm_pkg::t_dp_sts sts;

    pdcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    pdcm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_level        (i_level),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_duty_percent (o_duty_percent),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;

    localparam bit ACT_TICK  = 1'b0;
    localparam bit ACT_START = 1'b1;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    typedef enum logic [1:0] {
        MP_IDLE  = 2'd0,
        MP_RISE1 = 2'd1,
        MP_FALL  = 2'd2,
        MP_RISE2 = 2'd3
    } t_meter_phase;

    typedef struct packed {
        logic [pdcm_pkg::DUTY_W-1:0] duty;
        logic [pdcm_pkg::STAT_W-1:0] status;
    } t_duty_result;

    // Tracks the meter state and queues the duty results it must produce.
    class duty_meter_model;
        logic [pdcm_pkg::TO_W-1:0]  limit;
        t_meter_phase               phase;
        logic [pdcm_pkg::CNT_W-1:0] count;
        logic [pdcm_pkg::CNT_W-1:0] rise_at;
        logic [pdcm_pkg::CNT_W-1:0] fall_at;
        logic [pdcm_pkg::TO_W-1:0]  wait_cnt;
        logic                       last_lvl;
        t_duty_result               duty_q[$];
        int unsigned                made;
        int unsigned                n_ok;
        int unsigned                n_timeout;
        int unsigned                n_zero;
        int unsigned                n_sat;
        int unsigned                errors;

        function new();
            limit     = pdcm_pkg::TIMEOUT_RESET;
            phase     = MP_IDLE;
            count     = '0;
            rise_at   = '0;
            fall_at   = '0;
            wait_cnt  = '0;
            last_lvl  = 1'b0;
            made      = 0;
            n_ok      = 0;
            n_timeout = 0;
            n_zero    = 0;
            n_sat     = 0;
            errors    = 0;
        endfunction

        function int pending();
            return duty_q.size();
        endfunction

        function void finish_meas(logic [pdcm_pkg::DUTY_W-1:0] duty,
                                  logic [pdcm_pkg::STAT_W-1:0] status);
            t_duty_result r;
            r.duty   = duty;
            r.status = status;
            duty_q.push_back(r);
            made++;
            if (status == pdcm_pkg::ST_OK) n_ok++;
            else if (status == pdcm_pkg::ST_TIMEOUT) n_timeout++;
            else n_zero++;
            phase    = MP_IDLE;
            wait_cnt = '0;
        endfunction

        function void take_item(bit act, bit lvl);
            bit                         rose;
            bit                         fell;
            bit                         hit;
            logic [pdcm_pkg::CNT_W-1:0] period;
            logic [pdcm_pkg::CNT_W-1:0] high;
            int unsigned                quo;
            int unsigned                eff;
            if (act == ACT_START) begin
                phase    = MP_RISE1;
                wait_cnt = '0;
                return;
            end
            count    = count + 1'b1;
            rose     = lvl && !last_lvl;
            fell     = !lvl && last_lvl;
            last_lvl = lvl;
            if (phase == MP_IDLE)
                return;
            hit = (phase == MP_FALL) ? fell : rose;
            if (hit) begin
                case (phase)
                    MP_RISE1: begin
                        rise_at  = count;
                        phase    = MP_FALL;
                        wait_cnt = '0;
                    end
                    MP_FALL: begin
                        fall_at  = count;
                        phase    = MP_RISE2;
                        wait_cnt = '0;
                    end
                    default: begin
                        period = count - rise_at;
                        high   = fall_at - rise_at;
                        if (period == '0) begin
                            finish_meas(pdcm_pkg::DUTY_ZERO, pdcm_pkg::ST_ZERO);
                        end else begin
                            quo = (32'(high) * 32'(pdcm_pkg::PERCENT_SCALE)) / 32'(period);
                            // wrapped period shorter than the high time
                            if (quo > 32'(pdcm_pkg::PERCENT_SCALE)) begin
                                quo = 32'(pdcm_pkg::PERCENT_SCALE);
                                n_sat++;
                            end
                            finish_meas(pdcm_pkg::DUTY_W'(quo), pdcm_pkg::ST_OK);
                        end
                    end
                endcase
                return;
            end
            eff      = (limit == '0) ? 1 : 32'(limit);
            wait_cnt = wait_cnt + 1'b1;
            if (32'(wait_cnt) >= eff)
                finish_meas(pdcm_pkg::DUTY_ZERO, pdcm_pkg::ST_TIMEOUT);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [pdcm_pkg::DUTY_W-1:0] duty,
                                   logic [pdcm_pkg::STAT_W-1:0] status);
            t_duty_result want;
            if (duty_q.size() == 0) begin
                flag($sformatf("unexpected result: duty %0d status %0d", duty, status));
                return;
            end
            want = duty_q.pop_front();
            if (want.duty !== duty || want.status !== status)
                flag($sformatf("mismatch: expected duty %0d status %0d, got duty %0d status %0d",
                               want.duty, want.status, duty, status));
        endfunction
    endclass

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic                        i_action      = 1'b0;
    logic                        i_level       = 1'b0;
    logic                        i_cfg_wr_en   = 1'b0;
    logic [pdcm_pkg::TO_W-1:0]   i_cfg_wr_data = '0;
    logic                        i_stall       = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [pdcm_pkg::DUTY_W-1:0] o_duty_percent;
    logic [pdcm_pkg::STAT_W-1:0] o_status;

    duty_meter_model model = new();

    bit          idle_on    = 1'b0;
    bit          stall_on   = 1'b0;
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    int unsigned cycles     = 0;
    logic [15:0] stall_pat  = '0;
    logic [3:0]  stall_pos  = '0;

    pwm_duty_cycle_meter_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_level        (i_level),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_duty_percent (o_duty_percent),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, model.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            model.check_result(o_duty_percent, o_status);
    end

    // Receiver backpressure: reload a fresh 16-bit pattern each time the bit position wraps.
    always @(negedge i_clk) begin
        if (stall_pos == '0) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_pat = 16'($urandom & $urandom);
                end
                1: begin
                    stall_pat = 16'($urandom | $urandom);
                end
                2: begin
                    stall_pat = 16'hFFFF;
                end
                default: begin
                    stall_pat = 16'($urandom);
                end
            endcase
        end
        i_stall   = stall_on & stall_pat[stall_pos];
        stall_pos = stall_pos + 1'b1;
    end

    task automatic send_item(bit act, bit lvl);
        int unsigned gap;
        if (idle_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_valid  = 1'b1;
        i_action = act;
        i_level  = lvl;
        do @(posedge i_clk); while (o_stall);
        model.take_item(act, lvl);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_tick(bit lvl);
        send_item(ACT_TICK, lvl);
    endtask

    task automatic hold_level(bit lvl, int unsigned n);
        repeat (n) send_tick(lvl);
    endtask

    // Arm, then drive low / high / low / high runs of the given lengths.
    task automatic measure(int unsigned lo0, int unsigned hi, int unsigned lo, int unsigned hi2);
        send_item(ACT_START, 1'($urandom));
        hold_level(1'b0, lo0);
        hold_level(1'b1, hi);
        hold_level(1'b0, lo);
        hold_level(1'b1, hi2);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (model.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [pdcm_pkg::TO_W-1:0] value);
        // toggle the pin until any armed measurement closes
        while (model.phase != MP_IDLE) send_tick(!model.last_lvl);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(posedge i_clk);
        model.limit = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic random_phase(logic [pdcm_pkg::TO_W-1:0] lim, int unsigned maxw, bit gaps,
                                bit stalls, bit pause_mid);
        int unsigned n0;
        int unsigned r0;
        int unsigned sel;
        write_timeout(lim);
        idle_on  = gaps;
        stall_on = stalls;
        n0 = items_sent;
        r0 = model.made;
        while (items_sent - n0 < 50 || model.made - r0 < 5) begin
            if (pause_mid && items_sent - n0 >= 25) begin
                drain();
                pause_mid = 1'b0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                measure($urandom_range(0, maxw), $urandom_range(1, maxw),
                        $urandom_range(1, maxw), $urandom_range(1, 3));
            end else if (sel < 80) begin
                // abandoned measurement, restarted by a later start
                send_item(ACT_START, 1'($urandom));
                repeat ($urandom_range(0, 4)) send_tick(1'($urandom));
            end else if (sel < 90) begin
                repeat ($urandom_range(1, 6))
                    send_item(($urandom_range(0, 5) == 0) ? ACT_START : ACT_TICK, 1'($urandom));
            end else begin
                send_item(ACT_START, 1'($urandom));
                hold_level(1'($urandom), $urandom_range(1, 2 * maxw));
            end
        end
    endtask

    initial begin
        int unsigned lim;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset limit, receiver stalling
        stall_on = 1'b1;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        measure(2, 1, 15, 1);
        measure(1, 19, 1, 1);
        measure(1, 5, 5, 1);
        send_item(ACT_START, 1'b0);
        hold_level(1'b0, 1);
        hold_level(1'b1, 3);
        measure(1, 3, 1, 2);

        write_timeout(pdcm_pkg::TO_W'(1));
        send_tick(1'b0);
        measure(0, 1, 1, 1);
        measure(3, 1, 1, 1);

        // a run just inside the limit, then runs just past it in each phase
        write_timeout(pdcm_pkg::TO_W'(8));
        measure(1, 8, 1, 1);
        measure(1, 9, 1, 1);
        measure(1, 2, 9, 1);
        measure(9, 1, 1, 1);

        lim = $urandom_range(2, 10);
        random_phase(pdcm_pkg::TO_W'(lim), lim + 2, 1'b1, 1'b1, 1'b1);
        random_phase(pdcm_pkg::TO_W'(1), 2, 1'b1, 1'b0, 1'b0);
        random_phase(pdcm_pkg::TO_W'($urandom_range(1000, 65534)), 12, 1'b0, 1'b1, 1'b0);
        random_phase(pdcm_pkg::TO_W'(65535), 16, 1'b1, 1'b1, 1'b0);
        lim = $urandom_range(11, 40);
        random_phase(pdcm_pkg::TO_W'(lim), lim / 2, 1'b0, 1'b0, 1'b0);

        drain();
        repeat (SETTLE_CYCLES * 2) @(negedge i_clk);
        if (model.pending() != 0)
            model.flag($sformatf("%0d expected results never arrived", model.pending()));

        $display("covered %0d items with timeout limits from 1 to 65535 in %0d cycles",
                 items_sent, cycles);
        $display("results: %0d ok (%0d saturated), %0d timeouts, %0d zero periods, %0d errors",
                 model.n_ok, model.n_sat, model.n_timeout, model.n_zero, model.errors);
        if (model.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
design/pdcm_pkg.sv
design/pdcm_ctrl.sv
design/pdcm_dp.sv
design/pwm_duty_cycle_meter_core.sv
sim/testbench.sv
